FILE: rtl/proxy_negotiation_parser_defines.svh
// Assertion macros shared by the proxy negotiation parser RTL.
// Used by files that include this header; expects clk and rst_n in scope.
`ifndef PROXY_NEGOTIATION_PARSER_DEFINES_SVH
`define PROXY_NEGOTIATION_PARSER_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define PNP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PNP_ASSERT_NEXT(label, ante, cons, msg) \
  `PNP_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/pnp_pkg.sv
// Shared types and constants of the proxy negotiation parser.
// No dependencies; imported by the parser, emitter and top level.
`timescale 1ns / 1ps
`default_nettype none

package pnp_pkg;

  localparam int PNP_CRED_BYTES = 8;

  // result kinds
  localparam logic [2:0] KIND_REPLY   = 3'd0;
  localparam logic [2:0] KIND_DOMAIN  = 3'd1;
  localparam logic [2:0] KIND_CONNECT = 3'd2;
  localparam logic [2:0] KIND_CLOSE   = 3'd3;
  localparam logic [2:0] KIND_FORWARD = 3'd4;

  // close reasons
  localparam logic [3:0] RSN_NONE       = 4'd0;
  localparam logic [3:0] RSN_GREET_VER  = 4'd1;
  localparam logic [3:0] RSN_NO_METHODS = 4'd2;
  localparam logic [3:0] RSN_NO_METHOD  = 4'd3;
  localparam logic [3:0] RSN_AUTH_VER   = 4'd4;
  localparam logic [3:0] RSN_EMPTY_USER = 4'd5;
  localparam logic [3:0] RSN_EMPTY_PASS = 4'd6;
  localparam logic [3:0] RSN_MISMATCH   = 4'd7;
  localparam logic [3:0] RSN_REQ_VER    = 4'd8;
  localparam logic [3:0] RSN_CMD        = 4'd9;
  localparam logic [3:0] RSN_ATYPE      = 4'd10;

  // protocol bytes
  localparam logic [7:0] SOCKS_VER      = 8'h05;
  localparam logic [7:0] AUTH_VER       = 8'h01;
  localparam logic [7:0] METH_NONE      = 8'h00;
  localparam logic [7:0] METH_USERPASS  = 8'h02;
  localparam logic [7:0] METH_REJECT    = 8'hFF;
  localparam logic [7:0] CMD_CONNECT    = 8'h01;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
  localparam logic [7:0] REP_BAD_CMD    = 8'h07;
  localparam logic [7:0] REP_BAD_ATYP   = 8'h08;
  localparam logic [7:0] STATUS_OK      = 8'h00;
  localparam logic [7:0] STATUS_FAIL    = 8'h01;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;

  // result sequence shapes produced by one client byte
  typedef enum logic [2:0] {
    SEQ_ONE,        // single result, fields as given
    SEQ_CLOSE,      // close only
    SEQ_TWO,        // two reply bytes
    SEQ_TWO_CLOSE,  // two reply bytes, then close
    SEQ_ERR         // ten-byte error reply, then close
  } pnp_seq_t;

  typedef struct packed {
    logic        valid;
    pnp_seq_t    seq;
    logic [2:0]  kind;
    logic [7:0]  data0;
    logic [7:0]  data1;
    logic [31:0] ipv4;
    logic [15:0] port;
    logic        is_domain;
    logic [7:0]  dlen;
    logic [3:0]  reason;
  } pnp_desc_t;

endpackage

`default_nettype wire

FILE: rtl/pnp_parser.sv
// Per-byte handshake state machine of the proxy negotiation parser.
// Depends on pnp_pkg; hands a result descriptor to pnp_emitter.
`timescale 1ns / 1ps
`default_nettype none

`include "proxy_negotiation_parser_defines.svh"

module pnp_parser #(
  parameter int CRED_BYTES = pnp_pkg::PNP_CRED_BYTES
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      acc,
  input  wire                      restart,
  input  wire [7:0]                rx_byte,
  input  wire                      auth_required,
  input  wire [3:0]                user_length,
  input  wire [CRED_BYTES*8-1:0]   user_bytes,
  input  wire [3:0]                pass_length,
  input  wire [CRED_BYTES*8-1:0]   pass_bytes,
  output pnp_pkg::pnp_desc_t       desc
);
  import pnp_pkg::*;

  localparam int         IDX_W  = (CRED_BYTES > 1) ? $clog2(CRED_BYTES) : 1;
  localparam logic [7:0] CRED_N = 8'(CRED_BYTES);
  localparam logic [3:0] CRED_L = 4'(CRED_BYTES);

  typedef enum logic [4:0] {
    PH_GREET_VER, PH_GREET_NM, PH_GREET_M, PH_AUTH_VER, PH_AUTH_ULEN,
    PH_AUTH_USER, PH_AUTH_PLEN, PH_AUTH_PASS, PH_REQ_VER, PH_REQ_CMD,
    PH_REQ_RSV, PH_REQ_ATYP, PH_IPV4, PH_DOM_LEN, PH_DOM, PH_PORT_HI,
    PH_PORT_LO, PH_FORWARD, PH_CLOSED
  } phase_t;

  phase_t      phase_r, phase_nxt, cur_phase;
  logic [7:0]  rem_r, rem_nxt, cur_rem;
  logic [7:0]  fi_r, fi_nxt, cur_fi;
  logic [1:0]  meth_r, meth_nxt, cur_meth;
  logic        match_r, match_nxt, cur_match;
  logic        cmd_ok_r, cmd_ok_nxt, cur_cmd_ok;
  logic        is_dom_r, is_dom_nxt, cur_is_dom;
  logic [31:0] addr_r, addr_nxt, cur_addr;
  logic [7:0]  port_hi_r, port_hi_nxt, cur_port_hi;
  logic [7:0]  nlen_r, nlen_nxt, cur_nlen;

  // restart puts the connection state back before the byte is handled
  assign cur_phase   = restart ? PH_GREET_VER : phase_r;
  assign cur_rem     = restart ? 8'd0  : rem_r;
  assign cur_fi      = restart ? 8'd0  : fi_r;
  assign cur_meth    = restart ? 2'd0  : meth_r;
  assign cur_match   = restart ? 1'b1  : match_r;
  assign cur_cmd_ok  = restart ? 1'b0  : cmd_ok_r;
  assign cur_is_dom  = restart ? 1'b0  : is_dom_r;
  assign cur_addr    = restart ? 32'd0 : addr_r;
  assign cur_port_hi = restart ? 8'd0  : port_hi_r;
  assign cur_nlen    = restart ? 8'd0  : nlen_r;

  // stored lengths above CRED_BYTES count as CRED_BYTES
  logic [7:0] user_eff, pass_eff;
  assign user_eff = {4'd0, (user_length > CRED_L) ? CRED_L : user_length};
  assign pass_eff = {4'd0, (pass_length > CRED_L) ? CRED_L : pass_length};

  // credential byte compare, shared by username and password phases
  logic [CRED_BYTES*8-1:0] cred_sel;
  logic [IDX_W-1:0]        fi_idx;
  logic                    cred_ok;
  logic [7:0]              rem_dec;
  logic [1:0]              meth_upd;
  assign cred_sel = (cur_phase == PH_AUTH_PASS) ? pass_bytes : user_bytes;
  assign fi_idx   = cur_fi[IDX_W-1:0];
  assign cred_ok  = (cur_fi < CRED_N) && (cred_sel[{fi_idx, 3'b000} +: 8] == rx_byte);
  assign rem_dec  = cur_rem - 8'd1;
  assign meth_upd = cur_meth | {rx_byte == METH_USERPASS, rx_byte == METH_NONE};

  always_comb begin
    phase_nxt   = cur_phase;
    rem_nxt     = cur_rem;
    fi_nxt      = cur_fi;
    meth_nxt    = cur_meth;
    match_nxt   = cur_match;
    cmd_ok_nxt  = cur_cmd_ok;
    is_dom_nxt  = cur_is_dom;
    addr_nxt    = cur_addr;
    port_hi_nxt = cur_port_hi;
    nlen_nxt    = cur_nlen;
    desc        = '0;
    desc.seq    = SEQ_ONE;

    unique case (cur_phase)
      PH_GREET_VER: begin
        if (rx_byte != SOCKS_VER) begin
          desc.valid = 1'b1; desc.seq = SEQ_CLOSE; desc.reason = RSN_GREET_VER;
          phase_nxt  = PH_CLOSED;
        end else begin
          phase_nxt = PH_GREET_NM;
        end
      end
      PH_GREET_NM: begin
        if (rx_byte == 8'd0) begin
          desc.valid = 1'b1; desc.seq = SEQ_CLOSE; desc.reason = RSN_NO_METHODS;
          phase_nxt  = PH_CLOSED;
        end else begin
          rem_nxt   = rx_byte;
          meth_nxt  = 2'd0;
          phase_nxt = PH_GREET_M;
        end
      end
      PH_GREET_M: begin
        meth_nxt = meth_upd;
        rem_nxt  = rem_dec;
        if (rem_dec == 8'd0) begin
          desc.valid = 1'b1;
          desc.data0 = SOCKS_VER;
          if (auth_required && meth_upd[1]) begin
            desc.seq = SEQ_TWO; desc.data1 = METH_USERPASS;
            phase_nxt = PH_AUTH_VER;
          end else if (!auth_required && meth_upd[0]) begin
            desc.seq = SEQ_TWO; desc.data1 = METH_NONE;
            phase_nxt = PH_REQ_VER;
          end else begin
            desc.seq = SEQ_TWO_CLOSE; desc.data1 = METH_REJECT;
            desc.reason = RSN_NO_METHOD;
            phase_nxt = PH_CLOSED;
          end
        end
      end
      PH_AUTH_VER: begin
        if (rx_byte != AUTH_VER) begin
          desc.valid = 1'b1; desc.seq = SEQ_CLOSE; desc.reason = RSN_AUTH_VER;
          phase_nxt  = PH_CLOSED;
        end else begin
          phase_nxt = PH_AUTH_ULEN;
        end
      end
      PH_AUTH_ULEN: begin
        if (rx_byte == 8'd0) begin
          desc.valid = 1'b1; desc.seq = SEQ_CLOSE; desc.reason = RSN_EMPTY_USER;
          phase_nxt  = PH_CLOSED;
        end else begin
          rem_nxt   = rx_byte;
          fi_nxt    = 8'd0;
          match_nxt = (rx_byte == user_eff);
          phase_nxt = PH_AUTH_USER;
        end
      end
      PH_AUTH_USER: begin
        match_nxt = cur_match & cred_ok;
        fi_nxt    = cur_fi + 8'd1;
        rem_nxt   = rem_dec;
        if (rem_dec == 8'd0) phase_nxt = PH_AUTH_PLEN;
      end
      PH_AUTH_PLEN: begin
        if (rx_byte == 8'd0) begin
          desc.valid = 1'b1; desc.seq = SEQ_CLOSE; desc.reason = RSN_EMPTY_PASS;
          phase_nxt  = PH_CLOSED;
        end else begin
          rem_nxt   = rx_byte;
          fi_nxt    = 8'd0;
          match_nxt = cur_match & (rx_byte == pass_eff);
          phase_nxt = PH_AUTH_PASS;
        end
      end
      PH_AUTH_PASS: begin
        match_nxt = cur_match & cred_ok;
        fi_nxt    = cur_fi + 8'd1;
        rem_nxt   = rem_dec;
        if (rem_dec == 8'd0) begin
          desc.valid = 1'b1;
          desc.data0 = AUTH_VER;
          if (cur_match && cred_ok) begin
            desc.seq = SEQ_TWO; desc.data1 = STATUS_OK;
            phase_nxt = PH_REQ_VER;
          end else begin
            desc.seq = SEQ_TWO_CLOSE; desc.data1 = STATUS_FAIL;
            desc.reason = RSN_MISMATCH;
            phase_nxt = PH_CLOSED;
          end
        end
      end
      PH_REQ_VER: begin
        if (rx_byte != SOCKS_VER) begin
          desc.valid = 1'b1; desc.seq = SEQ_CLOSE; desc.reason = RSN_REQ_VER;
          phase_nxt  = PH_CLOSED;
        end else begin
          phase_nxt = PH_REQ_CMD;
        end
      end
      PH_REQ_CMD: begin
        cmd_ok_nxt = (rx_byte == CMD_CONNECT);
        phase_nxt  = PH_REQ_RSV;
      end
      PH_REQ_RSV: phase_nxt = PH_REQ_ATYP;
      PH_REQ_ATYP: begin
        is_dom_nxt  = (rx_byte == ATYP_DOMAIN);
        addr_nxt    = 32'd0;
        port_hi_nxt = 8'd0;
        nlen_nxt    = 8'd0;
        fi_nxt      = 8'd0;
        // bad command is reported ahead of a bad address type
        if (!cur_cmd_ok) begin
          desc.valid = 1'b1; desc.seq = SEQ_ERR; desc.data0 = SOCKS_VER;
          desc.data1 = REP_BAD_CMD; desc.reason = RSN_CMD;
          phase_nxt  = PH_CLOSED;
        end else if (rx_byte == ATYP_IPV4) begin
          phase_nxt = PH_IPV4;
        end else if (rx_byte == ATYP_DOMAIN) begin
          phase_nxt = PH_DOM_LEN;
        end else begin
          desc.valid = 1'b1; desc.seq = SEQ_ERR; desc.data0 = SOCKS_VER;
          desc.data1 = REP_BAD_ATYP; desc.reason = RSN_ATYPE;
          phase_nxt  = PH_CLOSED;
        end
      end
      PH_IPV4: begin
        addr_nxt = {cur_addr[23:0], rx_byte};
        fi_nxt   = cur_fi + 8'd1;
        if (cur_fi + 8'd1 >= 8'd4) phase_nxt = PH_PORT_HI;
      end
      PH_DOM_LEN: begin
        nlen_nxt  = rx_byte;
        rem_nxt   = rx_byte;
        phase_nxt = (rx_byte == 8'd0) ? PH_PORT_HI : PH_DOM;
      end
      PH_DOM: begin
        desc.valid = 1'b1; desc.kind = KIND_DOMAIN; desc.data0 = rx_byte;
        rem_nxt    = rem_dec;
        if (rem_dec == 8'd0) phase_nxt = PH_PORT_HI;
      end
      PH_PORT_HI: begin
        port_hi_nxt = rx_byte;
        phase_nxt   = PH_PORT_LO;
      end
      PH_PORT_LO: begin
        port_hi_nxt    = 8'd0;
        desc.valid     = 1'b1;
        desc.kind      = KIND_CONNECT;
        desc.port      = {cur_port_hi, rx_byte};
        desc.is_domain = cur_is_dom;
        desc.ipv4      = cur_is_dom ? 32'd0 : cur_addr;
        desc.dlen      = cur_is_dom ? cur_nlen : 8'd0;
        phase_nxt      = PH_FORWARD;
      end
      PH_FORWARD: begin
        desc.valid = 1'b1; desc.kind = KIND_FORWARD; desc.data0 = rx_byte;
      end
      PH_CLOSED: phase_nxt = PH_CLOSED;
      default:   phase_nxt = PH_CLOSED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_GREET_VER;
      rem_r     <= 8'd0;
      fi_r      <= 8'd0;
      meth_r    <= 2'd0;
      match_r   <= 1'b1;
      cmd_ok_r  <= 1'b0;
      is_dom_r  <= 1'b0;
      addr_r    <= 32'd0;
      port_hi_r <= 8'd0;
      nlen_r    <= 8'd0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      fi_r      <= fi_nxt;
      meth_r    <= meth_nxt;
      match_r   <= match_nxt;
      cmd_ok_r  <= cmd_ok_nxt;
      is_dom_r  <= is_dom_nxt;
      addr_r    <= addr_nxt;
      port_hi_r <= port_hi_nxt;
      nlen_r    <= nlen_nxt;
    end
  end

  // byte accepted on a closed connection without restart
  logic closed_hit;
  assign closed_hit = acc && !restart && (phase_r == PH_CLOSED);

  `PNP_ASSERT(a_closed_silent, closed_hit |-> !desc.valid, "result while closed")
  `PNP_ASSERT_NEXT(a_closed_sticks, closed_hit, phase_r == PH_CLOSED, "closed state left")
  `PNP_ASSERT(a_ipv4_index, (phase_r == PH_IPV4) |-> (fi_r < 8'd4), "address index overran")

endmodule

`default_nettype wire

FILE: rtl/pnp_emitter.sv
// Result sequencer: holds one descriptor and plays out its results in order.
// Depends on pnp_pkg; fed by pnp_parser.
`timescale 1ns / 1ps
`default_nettype none

`include "proxy_negotiation_parser_defines.svh"

module pnp_emitter (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  pnp_pkg::pnp_desc_t  desc,
  output logic                free,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [2:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic [31:0]         out_target_ipv4,
  output logic [15:0]         out_target_port,
  output logic                out_address_is_domain,
  output logic [7:0]          out_domain_length,
  output logic [3:0]          out_close_reason,
  output logic                out_last
);
  import pnp_pkg::*;

  pnp_desc_t  desc_r;
  logic       busy_r;
  logic [3:0] step_r;
  logic [3:0] last_step;
  logic       has_close, is_final, fin;

  always_comb begin
    unique case (desc_r.seq)
      SEQ_ONE:       begin last_step = 4'd0;  has_close = 1'b0; end
      SEQ_CLOSE:     begin last_step = 4'd0;  has_close = 1'b1; end
      SEQ_TWO:       begin last_step = 4'd1;  has_close = 1'b0; end
      SEQ_TWO_CLOSE: begin last_step = 4'd2;  has_close = 1'b1; end
      SEQ_ERR:       begin last_step = 4'd10; has_close = 1'b1; end
      default:       begin last_step = 4'd0;  has_close = 1'b0; end
    endcase
  end

  assign is_final  = (step_r == last_step);
  assign fin       = busy_r && !out_stall && is_final;
  assign free      = !busy_r || fin;
  assign out_valid = busy_r;
  assign out_last  = is_final;

  always_comb begin
    out_kind              = KIND_REPLY;
    out_byte              = ZERO_BYTE;
    out_target_ipv4       = 32'd0;
    out_target_port       = 16'd0;
    out_address_is_domain = 1'b0;
    out_domain_length     = 8'd0;
    out_close_reason      = RSN_NONE;
    if (desc_r.seq == SEQ_ONE) begin
      out_kind              = desc_r.kind;
      out_byte              = desc_r.data0;
      out_target_ipv4       = desc_r.ipv4;
      out_target_port       = desc_r.port;
      out_address_is_domain = desc_r.is_domain;
      out_domain_length     = desc_r.dlen;
    end else if (has_close && is_final) begin
      out_kind         = KIND_CLOSE;
      out_close_reason = desc_r.reason;
    end else if (step_r == 4'd0) begin
      out_byte = desc_r.data0;
    end else if (step_r == 4'd1) begin
      out_byte = desc_r.data1;
    end else if (desc_r.seq == SEQ_ERR && step_r == 4'd3) begin
      out_byte = ATYP_IPV4;  // bound address type field of the error reply
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 4'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      step_r <= 4'd0;
    end else if (fin) begin
      busy_r <= 1'b0;
      step_r <= 4'd0;
    end else if (busy_r && !out_stall) begin
      step_r <= step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) desc_r <= desc;
  end

  // result shown but held off by the receiver
  logic out_held;
  assign out_held = out_valid && out_stall;

  `PNP_ASSERT(a_load_when_free, load |-> free, "descriptor loaded over a pending one")
  `PNP_ASSERT(a_step_bound, busy_r |-> (step_r <= last_step), "step ran past end of sequence")
  `PNP_ASSERT_NEXT(a_stall_holds, out_held, out_valid && $stable(step_r), "held result moved")

endmodule

`default_nettype wire

FILE: rtl/proxy_negotiation_parser.sv
// Top level of the SOCKS5-style proxy negotiation parser.
// Depends on pnp_pkg, pnp_parser and pnp_emitter.
//
// Usage:
//   Input channel (in_valid / in_stall): one client byte per transaction,
//   with in_restart to begin a new connection ahead of that byte.
//   Output channel (out_valid / out_stall): one result per transaction
//   (reply byte, domain byte, connect, close or forwarded byte); out_last
//   marks the final result caused by a given input byte.
//   Config port: APB-style, 64-bit data, registers at 8-byte strides.
//   Write only while the block is idle.
// Timing: a byte's first result is shown in the cycle after the byte is
//   accepted. A byte with at most one result frees the sequencer once it
//   is taken, so forwarding runs at one byte per clock while out_stall is
//   low. Bytes with k results (two for method and auth replies, three with
//   a close, eleven for an error reply) play out in order from the single
//   descriptor register of the sequencer; no new byte enters until the last is.
// Reset: rst_n (synchronous) clears all config registers and returns the
//   parser to the greeting version byte; the output channel goes empty.
// Stall: while out_stall is high the shown result holds; in_stall rises
//   once the sequencer holds results that cannot drain this cycle.
`timescale 1ns / 1ps
`default_nettype none

module proxy_negotiation_parser #(
  parameter int CRED_BYTES = pnp_pkg::PNP_CRED_BYTES
) (
  input  wire         clk,
  input  wire         rst_n,
  // client byte input
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_restart,
  input  wire  [7:0]  in_rx_byte,
  // result output
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] out_target_ipv4,
  output logic [15:0] out_target_port,
  output logic        out_address_is_domain,
  output logic [7:0]  out_domain_length,
  output logic [3:0]  out_close_reason,
  output logic        out_last,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [5:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import pnp_pkg::*;

  localparam int CRED_W = CRED_BYTES * 8;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_AUTH_REQUIRED = 3'd0;
  localparam logic [2:0] REG_USER_LENGTH   = 3'd1;
  localparam logic [2:0] REG_USER_BYTES    = 3'd2;
  localparam logic [2:0] REG_PASS_LENGTH   = 3'd3;
  localparam logic [2:0] REG_PASS_BYTES    = 3'd4;

  // ---------------------------------------------------------------
  // Config registers. Only the first CRED_BYTES bytes of a stored
  // credential can ever be compared, so only those are kept.
  // ---------------------------------------------------------------
  logic              auth_r;
  logic [3:0]        ulen_r, plen_r;
  logic [CRED_W-1:0] user_r, pass_r;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auth_r <= 1'b0;
      ulen_r <= 4'd0;
      plen_r <= 4'd0;
      user_r <= '0;
      pass_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_AUTH_REQUIRED: auth_r <= pwdata[0];
        REG_USER_LENGTH:   ulen_r <= pwdata[3:0];
        REG_USER_BYTES:    user_r <= pwdata[CRED_W-1:0];
        REG_PASS_LENGTH:   plen_r <= pwdata[3:0];
        REG_PASS_BYTES:    pass_r <= pwdata[CRED_W-1:0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AUTH_REQUIRED: prdata = {63'd0, auth_r};
      REG_USER_LENGTH:   prdata = {60'd0, ulen_r};
      REG_USER_BYTES:    prdata = 64'(user_r);
      REG_PASS_LENGTH:   prdata = {60'd0, plen_r};
      REG_PASS_BYTES:    prdata = 64'(pass_r);
      default:           prdata = 64'd0;
    endcase
  end

  // ---------------------------------------------------------------
  // Datapath: parser updates connection state on each accepted byte
  // and produces a descriptor; the emitter registers it and plays
  // out the result transactions.
  // ---------------------------------------------------------------
  pnp_desc_t desc;
  logic      acc;
  logic      seq_free;

  assign in_stall = !seq_free;
  assign acc      = in_valid && !in_stall;

  pnp_parser #(
    .CRED_BYTES (CRED_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .restart       (in_restart),
    .rx_byte       (in_rx_byte),
    .auth_required (auth_r),
    .user_length   (ulen_r),
    .user_bytes    (user_r),
    .pass_length   (plen_r),
    .pass_bytes    (pass_r),
    .desc          (desc)
  );

  // a byte with no results (most header bytes) never touches the emitter
  pnp_emitter u_emitter (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .load                  (acc && desc.valid),
    .desc                  (desc),
    .free                  (seq_free),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_byte              (out_byte),
    .out_target_ipv4       (out_target_ipv4),
    .out_target_port       (out_target_port),
    .out_address_is_domain (out_address_is_domain),
    .out_domain_length     (out_domain_length),
    .out_close_reason      (out_close_reason),
    .out_last              (out_last)
  );

endmodule

`default_nettype wire
